/* hdl/csa_pkg.sv */
// ---------------------------------------------------------------------------
// csa_pkg: shared types, tables and helpers for the CSA stream cipher
// Cipher state layout, word types, mode codes, S-box and tap tables.
// ---------------------------------------------------------------------------
package csa_pkg;

   localparam int RegBits = 40;   // ten 4-bit cells per shift register
   localparam int NumSbox = 7;

   typedef enum logic [1:0] {
      MODE_RESTART = 2'd0,
      MODE_INIT    = 2'd1,
      MODE_GEN     = 2'd2,
      MODE_NONE    = 2'd3
   } mode_type;

   typedef struct packed {
      logic [1:0] mode;
      logic [7:0] data_byte;
   } req_word_type;

   typedef struct packed {
      logic [7:0] keystream_byte;
      logic       byte_valid;
   } rsp_word_type;

   // Cell i sits at [39-4i -: 4], so cell 0 is the top nibble and cell 9 the bottom.
   typedef struct packed {
      logic [RegBits-1:0] reg_a;
      logic [RegBits-1:0] reg_b;
      logic [13:0]        comb;
      logic [3:0]         nib_d;
      logic [3:0]         nib_e;
      logic [3:0]         nib_f;
      logic               carry;
   } state_type;

   localparam logic [5:0] A_TAPS [0:NumSbox-1][0:4] = '{
      '{6'd16, 6'd2,  6'd23, 6'd25, 6'd36},
      '{6'd7,  6'd10, 6'd21, 6'd28, 6'd35},
      '{6'd1,  6'd8,  6'd19, 6'd17, 6'd22},
      '{6'd9,  6'd3,  6'd5,  6'd14, 6'd32},
      '{6'd18, 6'd13, 6'd24, 6'd31, 6'd34},
      '{6'd11, 6'd15, 6'd20, 6'd26, 6'd33},
      '{6'd6,  6'd12, 6'd27, 6'd30, 6'd29}};

   localparam logic [3:0] C_POS [0:NumSbox-1][0:1] = '{
      '{4'd4, 4'd10}, '{4'd3, 4'd9}, '{4'd8, 4'd2}, '{4'd7, 4'd1},
      '{4'd12, 4'd6}, '{4'd11, 4'd5}, '{4'd13, 4'd14}};

   localparam logic [5:0] B_TAPS [0:3][0:3] = '{
      '{6'd12, 6'd23, 6'd26, 6'd33},
      '{6'd9,  6'd14, 6'd24, 6'd31},
      '{6'd16, 6'd19, 6'd17, 6'd30},
      '{6'd11, 6'd21, 6'd32, 6'd34}};

   localparam logic [1:0] SBOX [0:NumSbox-1][0:31] = '{
      '{2'd2,2'd0,2'd1,2'd1,2'd2,2'd3,2'd3,2'd0, 2'd3,2'd2,2'd2,2'd0,2'd1,2'd1,2'd0,2'd3,
        2'd0,2'd3,2'd3,2'd0,2'd2,2'd2,2'd1,2'd1, 2'd2,2'd2,2'd0,2'd3,2'd1,2'd1,2'd3,2'd0},
      '{2'd3,2'd1,2'd0,2'd2,2'd2,2'd3,2'd3,2'd0, 2'd1,2'd3,2'd2,2'd1,2'd0,2'd0,2'd1,2'd2,
        2'd3,2'd1,2'd0,2'd3,2'd3,2'd2,2'd0,2'd2, 2'd0,2'd0,2'd1,2'd2,2'd2,2'd1,2'd3,2'd1},
      '{2'd2,2'd0,2'd1,2'd2,2'd2,2'd3,2'd3,2'd1, 2'd1,2'd1,2'd0,2'd3,2'd3,2'd0,2'd2,2'd0,
        2'd1,2'd3,2'd0,2'd1,2'd3,2'd0,2'd2,2'd2, 2'd2,2'd0,2'd1,2'd2,2'd0,2'd3,2'd3,2'd1},
      '{2'd3,2'd1,2'd2,2'd3,2'd0,2'd2,2'd1,2'd2, 2'd1,2'd2,2'd0,2'd1,2'd3,2'd0,2'd0,2'd3,
        2'd1,2'd0,2'd3,2'd1,2'd2,2'd3,2'd0,2'd3, 2'd0,2'd3,2'd2,2'd0,2'd1,2'd2,2'd2,2'd1},
      '{2'd2,2'd0,2'd0,2'd1,2'd3,2'd2,2'd3,2'd2, 2'd0,2'd1,2'd3,2'd3,2'd1,2'd0,2'd2,2'd1,
        2'd2,2'd3,2'd2,2'd0,2'd0,2'd3,2'd1,2'd1, 2'd1,2'd0,2'd3,2'd2,2'd3,2'd1,2'd0,2'd2},
      '{2'd0,2'd1,2'd2,2'd3,2'd1,2'd2,2'd2,2'd0, 2'd0,2'd1,2'd3,2'd0,2'd2,2'd3,2'd1,2'd3,
        2'd2,2'd3,2'd0,2'd2,2'd3,2'd0,2'd1,2'd1, 2'd2,2'd1,2'd1,2'd2,2'd0,2'd3,2'd3,2'd0},
      '{2'd0,2'd3,2'd2,2'd2,2'd3,2'd0,2'd0,2'd1, 2'd3,2'd0,2'd1,2'd3,2'd1,2'd2,2'd2,2'd1,
        2'd1,2'd0,2'd3,2'd3,2'd0,2'd1,2'd1,2'd2, 2'd2,2'd3,2'd1,2'd0,2'd2,2'd3,2'd0,2'd2}};

   // Tap t (1-based, tap 1 is MSB of cell 0) maps to vector bit 40-t.
   function automatic logic tap_bit(input logic [RegBits-1:0] vec, input logic [5:0] tap);
      logic [5:0] pos;
      pos = 6'(RegBits) - tap;
      return vec[pos];
   endfunction

endpackage

/* hdl/csa_round.sv */
// ---------------------------------------------------------------------------
// csa_round: one nibble round of the CSA stream cipher
// Combinational next state and two keystream bits for one round.
// ---------------------------------------------------------------------------
module csa_round (
   input  csa_pkg::state_type st_i,
   input  logic               init_i,
   input  logic [7:0]         in_byte_i,
   output csa_pkg::state_type st_o,
   output logic [1:0]         bits_o
);
   import csa_pkg::*;

   logic [3:0]  x_nib, y_nib, z_nib, x_new, y_mix, y_new, t3, d_new;
   logic        p_bit, q_bit;
   logic [13:0] comb_new;
   logic [4:0]  sel [0:NumSbox-1];
   logic [1:0]  sv  [0:NumSbox-1];
   logic [4:0]  sum;

   assign x_nib = st_i.comb[13:10];
   assign y_nib = st_i.comb[9:6];
   assign z_nib = st_i.comb[5:2];
   assign p_bit = st_i.comb[1];
   assign q_bit = st_i.comb[0];

   always_comb begin
      comb_new = '0;
      for (int k = 0; k < NumSbox; k++) begin
         for (int j = 0; j < 5; j++) begin
            sel[k][4-j] = tap_bit(st_i.reg_a, A_TAPS[k][j]);
         end
         sv[k] = SBOX[k][sel[k]];
         comb_new[4'(14 - C_POS[k][0])] = sv[k][1];
         comb_new[4'(14 - C_POS[k][1])] = sv[k][0];
      end
   end

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         t3[k] = tap_bit(st_i.reg_b, B_TAPS[3-k][0]) ^ tap_bit(st_i.reg_b, B_TAPS[3-k][1])
               ^ tap_bit(st_i.reg_b, B_TAPS[3-k][2]) ^ tap_bit(st_i.reg_b, B_TAPS[3-k][3]);
      end
   end

   assign d_new  = t3 ^ st_i.nib_e ^ z_nib;
   assign bits_o = {d_new[3] ^ d_new[2], d_new[1] ^ d_new[0]};
   assign sum    = {1'b0, st_i.nib_e} + {1'b0, z_nib} + {4'd0, st_i.carry};

   // cell 9 is the bottom nibble, cell 6 sits at [15:12]
   assign x_new = x_nib ^ st_i.reg_a[3:0] ^ (init_i ? (in_byte_i[7:4] ^ st_i.nib_d) : 4'd0);
   assign y_mix = y_nib ^ st_i.reg_b[3:0] ^ st_i.reg_b[15:12] ^ (init_i ? in_byte_i[3:0] : 4'd0);
   assign y_new = p_bit ? {y_mix[2:0], y_mix[3]} : y_mix;

   always_comb begin
      st_o.reg_a = {x_new, st_i.reg_a[RegBits-1:4]};
      st_o.reg_b = {y_new, st_i.reg_b[RegBits-1:4]};
      st_o.comb  = comb_new;
      st_o.nib_d = d_new;
      st_o.nib_e = st_i.nib_f;
      st_o.nib_f = q_bit ? sum[3:0] : st_i.nib_e;
      st_o.carry = q_bit ? sum[4] : st_i.carry;
   end

endmodule

/* hdl/csa_stream_keystream.sv */
// ---------------------------------------------------------------------------
// csa_stream_keystream: DVB common scrambling stream cipher keystream
// Restart, init and generate words; four cipher rounds per init or generate word.
// ---------------------------------------------------------------------------
//  channel  ports                         direction  word
//  req      req_valid req_ready req_data  in         mode, data_byte
//  rsp      rsp_valid rsp_ready rsp_data  out        keystream_byte, byte_valid
//  csr      csr_valid csr_ready csr_data  in         64-bit control word
//
//  One word per cycle unless a response is stalled: the four rounds run between
//  the cipher state registers and the response register in the accepting cycle.
//  A response appears in the cycle after its request word is accepted.
//  A stalled response holds; req_ready stays high while rsp_ready is high.
//  Reset clears the control word and the cipher state; csr_ready is always high.
// ---------------------------------------------------------------------------
module csa_stream_keystream (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  csa_pkg::req_word_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output csa_pkg::rsp_word_type rsp_data,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [63:0]           csr_data
);
   import csa_pkg::*;

   state_type    st_ff, st_in;
   state_type    rnd_st [0:4];
   logic [1:0]   rnd_bits [0:3];
   logic [63:0]  ctrl_ff;
   rsp_word_type rsp_ff, rsp_in;
   logic         rsp_valid_ff;
   logic         req_fire, is_init;
   logic [7:0]   swapped;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign is_init   = (req_data.mode == MODE_INIT);
   assign swapped   = {req_data.data_byte[3:0], req_data.data_byte[7:4]};

   assign rnd_st[0] = st_ff;

   for (genvar r = 0; r < 4; r++) begin : g_round
      csa_round u_round (
         .st_i      (rnd_st[r]),
         .init_i    (is_init),
         .in_byte_i (r % 2 == 0 ? req_data.data_byte : swapped),
         .st_o      (rnd_st[r+1]),
         .bits_o    (rnd_bits[r])
      );
   end

   always_comb begin
      st_in  = st_ff;
      rsp_in = '0;
      case (req_data.mode)
         MODE_RESTART: begin
            st_in       = '0;
            st_in.reg_a = {ctrl_ff[63:32], 8'd0};
            st_in.reg_b = {ctrl_ff[31:0], 8'd0};
         end
         MODE_INIT: begin
            st_in = rnd_st[4];
         end
         MODE_GEN: begin
            st_in                 = rnd_st[4];
            rsp_in.keystream_byte = {rnd_bits[0], rnd_bits[1], rnd_bits[2], rnd_bits[3]};
            rsp_in.byte_valid     = 1'b1;
         end
         default: begin
            st_in = st_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= '0;
         ctrl_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            ctrl_ff <= csr_data;
         end
         if (req_fire) begin
            st_ff        <= st_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
